FILE: rtl/p2c_pkg.sv
// shared types, constants and table functions for the polar to cartesian converter
`timescale 1ns / 1ps

package p2c_pkg;

    // block configuration
    localparam int CORDIC_STAGES = 16;
    localparam int FRACTION_BITS = 16;

    // arctangent table size and the iterations actually run
    localparam int ATAN_ENTRIES = 30;
    localparam int CORDIC_ITERS = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;

    // field and datapath widths
    localparam int DATA_W    = 32;
    localparam int CORDIC_W  = DATA_W + 2;
    localparam int MUL_SHIFT = 30;
    localparam int PROD1_W   = 2 * DATA_W;
    localparam int RC_W      = PROD1_W - MUL_SHIFT;
    localparam int PROD2_W   = RC_W + DATA_W;
    localparam int VAL_W     = PROD2_W - MUL_SHIFT;

    // cordic start value, gain compensated, q30
    localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = CORDIC_W'(652032874);

    // pi/180 in q30
    localparam int DEG_RAD_W = 25;
    localparam logic [DEG_RAD_W-1:0] DEG_TO_RAD_Q30 = DEG_RAD_W'(18740330);

    // angle reduction constants, degrees with FRACTION_BITS fraction bits
    localparam longint unsigned QUARTER_ANGLE = 64'd90 << FRACTION_BITS;
    localparam longint unsigned FULL_ANGLE    = 64'd4 * QUARTER_ANGLE;
    localparam longint unsigned ANGLE_OFFSET  =
        ((64'd1 << (DATA_W - 1)) / FULL_ANGLE + 64'd1) * FULL_ANGLE;
    localparam int REDUCE_STEPS = $clog2((64'd1 << DATA_W) / FULL_ANGLE + 64'd2);
    localparam int WRAP_W = DATA_W + 1;
    localparam int MOD_W  = $clog2(FULL_ANGLE);
    localparam int FOLD_W = $clog2(QUARTER_ANGLE + 64'd1);
    localparam int PROD_W = FOLD_W + DEG_RAD_W;
    localparam longint unsigned ROUND_HALF = 64'd1 << (FRACTION_BITS - 1);

    // coordinate type codes
    typedef enum logic [1:0] {
        COORD_CARTESIAN   = 2'd0,
        COORD_CYLINDRICAL = 2'd1,
        COORD_SPHERICAL   = 2'd2,
        COORD_UNKNOWN     = 2'd3
    } p2c_coord_t;

    // one input item
    typedef struct packed {
        p2c_coord_t         operation;
        logic signed [31:0] first_component;
        logic signed [31:0] second_component;
        logic signed [31:0] third_component;
    } p2c_in_t;

    // one result item
    typedef struct packed {
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic signed [31:0] z_out;
        logic               type_valid;
        logic               saturated;
    } p2c_out_t;

    // quadrant signs kept beside a folded angle
    typedef struct packed {
        logic neg_sin;
        logic neg_cos;
    } p2c_quad_t;

    // reduced angles headed for the cordic
    typedef struct packed {
        p2c_in_t                    item;
        logic signed [CORDIC_W-1:0] az_angle;
        logic signed [CORDIC_W-1:0] po_angle;
        p2c_quad_t                  az_quad;
        p2c_quad_t                  po_quad;
    } p2c_ang_t;

    // sine and cosine of both angles, q30
    typedef struct packed {
        p2c_in_t                  item;
        logic signed [DATA_W-1:0] az_cos;
        logic signed [DATA_W-1:0] az_sin;
        logic signed [DATA_W-1:0] po_cos;
        logic signed [DATA_W-1:0] po_sin;
    } p2c_trig_t;

    // q30 arctangent of 2^-idx, truncated toward zero for idx up to 26
    function automatic logic signed [CORDIC_W-1:0] atan_q30(input int idx);
        logic [31:0] v;
        case (idx)
            0:       v = 32'h3243F6A8;
            1:       v = 32'h1DAC6705;
            2:       v = 32'h0FADBAFC;
            3:       v = 32'h07F56EA6;
            4:       v = 32'h03FEAB76;
            5:       v = 32'h01FFD55B;
            6:       v = 32'h00FFFAAA;
            7:       v = 32'h007FFF55;
            8:       v = 32'h003FFFEA;
            9:       v = 32'h001FFFFD;
            10:      v = 32'h000FFFFF;
            11:      v = 32'h0007FFFF;
            12:      v = 32'h0003FFFF;
            13:      v = 32'h0001FFFF;
            14:      v = 32'h0000FFFF;
            15:      v = 32'h00007FFF;
            16:      v = 32'h00003FFF;
            17:      v = 32'h00001FFF;
            18:      v = 32'h00000FFF;
            19:      v = 32'h000007FF;
            20:      v = 32'h000003FF;
            21:      v = 32'h000001FF;
            22:      v = 32'h000000FF;
            23:      v = 32'h0000007F;
            24:      v = 32'h0000003F;
            25:      v = 32'h0000001F;
            26:      v = 32'h0000000F;
            27:      v = 32'h00000008;
            28:      v = 32'h00000004;
            29:      v = 32'h00000002;
            default: v = 32'h00000000;
        endcase
        return CORDIC_W'(v);
    endfunction

    // multiple of a full turn removed in one reduction step
    function automatic logic [WRAP_W-1:0] wrap_step(input int k);
        return WRAP_W'(FULL_ANGLE << k);
    endfunction

endpackage

FILE: rtl/polar_to_cartesian_converter.sv
// top level of the polar to cartesian converter: angle, cordic and scale pipelines
// throughput: one item per cycle while the result is not held; every stage is a fully pipelined register stage
// stalls: a held result stops only the stages behind it until an empty stage is reached
// reset: clears every stage valid bit, so the pipeline is empty and ready right after reset
`timescale 1ns / 1ps

module polar_to_cartesian_converter (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              point_valid,
    output logic              point_ready,
    input  p2c_pkg::p2c_in_t  point,
    output logic              result_valid,
    input  logic              result_ready,
    output p2c_pkg::p2c_out_t result
);
    import p2c_pkg::*;

    logic      angle_valid;
    logic      angle_ready;
    p2c_ang_t  angle_item;
    logic      trig_valid;
    logic      trig_ready;
    p2c_trig_t trig_item;

    // angle wrap, fold and radian conversion
    p2c_angle u_angle (
        .clk         (clk),
        .rst_n       (rst_n),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .point       (point),
        .angle_valid (angle_valid),
        .angle_ready (angle_ready),
        .angle_item  (angle_item)
    );

    // sine and cosine of azimuth and polar angle
    p2c_cordic u_cordic (
        .clk         (clk),
        .rst_n       (rst_n),
        .angle_valid (angle_valid),
        .angle_ready (angle_ready),
        .angle_item  (angle_item),
        .trig_valid  (trig_valid),
        .trig_ready  (trig_ready),
        .trig_item   (trig_item)
    );

    // products, type select and saturation
    p2c_scale u_scale (
        .clk          (clk),
        .rst_n        (rst_n),
        .trig_valid   (trig_valid),
        .trig_ready   (trig_ready),
        .trig_item    (trig_item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    // input refused only when every stage is full and the result is held
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !point_ready |-> (result_valid && !result_ready))
        else $error("input stalled while the pipeline has room");

    // reduced angles are never negative
    a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
        angle_valid |-> (!angle_item.az_angle[CORDIC_W-1] && !angle_item.po_angle[CORDIC_W-1]))
        else $error("reduced angle out of range");

    // unknown type gives an all zero result
    a_unknown_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && !result.type_valid) |->
        (result.x_out == '0 && result.y_out == '0 && result.z_out == '0 && !result.saturated))
        else $error("unknown type item with nonzero result");

endmodule

FILE: rtl/p2c_angle.sv
// angle reduction pipeline: wrap to one turn, fold to a quadrant, convert to q30 radians
`timescale 1ns / 1ps

module p2c_angle (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               point_valid,
    output logic               point_ready,
    input  p2c_pkg::p2c_in_t   point,
    output logic               angle_valid,
    input  logic               angle_ready,
    output p2c_pkg::p2c_ang_t  angle_item
);
    import p2c_pkg::*;

    // stage map: offset, reduction steps, fold, multiply, round
    localparam int FOLD_S  = REDUCE_STEPS + 1;
    localparam int MUL_S   = REDUCE_STEPS + 2;
    localparam int ROUND_S = REDUCE_STEPS + 3;
    localparam int STAGES  = REDUCE_STEPS + 4;

    localparam logic [MOD_W-1:0] QTR_M   = MOD_W'(QUARTER_ANGLE);
    localparam logic [MOD_W-1:0] HALF_M  = MOD_W'(2 * QUARTER_ANGLE);
    localparam logic [MOD_W-1:0] THREE_M = MOD_W'(3 * QUARTER_ANGLE);
    localparam logic [MOD_W-1:0] FULL_M  = MOD_W'(FULL_ANGLE);

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] adv;

    p2c_in_t                    item_reg [0:STAGES-1];
    logic [WRAP_W-1:0]          wrap_reg [0:1][0:REDUCE_STEPS];
    logic [WRAP_W-1:0]          wrap_next [0:1][0:REDUCE_STEPS];
    p2c_quad_t                  quad_reg [0:1][0:2];
    p2c_quad_t                  quad_next [0:1];
    logic [FOLD_W-1:0]          fold_reg [0:1];
    logic [FOLD_W-1:0]          fold_next [0:1];
    logic [PROD_W-1:0]          prod_reg [0:1];
    logic [PROD_W-1:0]          prod_next [0:1];
    logic signed [CORDIC_W-1:0] ang_reg [0:1];
    logic signed [CORDIC_W-1:0] ang_next [0:1];
    logic [DATA_W-1:0]          lane_ang [0:1];
    logic [MOD_W-1:0]           mod_val [0:1];
    logic [PROD_W-1:0]          rnd_sum [0:1];

    // a stage moves when some stage at or after it is empty or the output drains
    always_comb
    begin
        for (int j = 0; j < STAGES; j++)
        begin
            adv[j] = angle_ready || (|(~vld_reg >> j));
        end
        vld_next = vld_reg;
        for (int j = 0; j < STAGES; j++)
        begin
            if (adv[j])
            begin
                vld_next[j] = (j == 0) ? point_valid : vld_reg[(j == 0) ? 0 : j - 1];
            end
        end
    end

    // wrap by adding whole turns, then restoring subtraction of turn multiples
    always_comb
    begin
        logic [WRAP_W-1:0] step;
        lane_ang[0] = point.second_component;
        lane_ang[1] = point.third_component;
        for (int l = 0; l < 2; l++)
        begin
            wrap_next[l][0] = {lane_ang[l][DATA_W-1], lane_ang[l]} + WRAP_W'(ANGLE_OFFSET);
            for (int s = 1; s <= REDUCE_STEPS; s++)
            begin
                step = wrap_step(REDUCE_STEPS - s);
                if (wrap_reg[l][s-1] >= step)
                begin
                    wrap_next[l][s] = wrap_reg[l][s-1] - step;
                end
                else
                begin
                    wrap_next[l][s] = wrap_reg[l][s-1];
                end
            end
        end
    end

    // fold into the first quadrant and convert to q30 radians
    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            mod_val[l] = wrap_reg[l][REDUCE_STEPS][MOD_W-1:0];
            quad_next[l] = '0;
            if (mod_val[l] <= QTR_M)
            begin
                fold_next[l] = FOLD_W'(mod_val[l]);
            end
            else if (mod_val[l] <= HALF_M)
            begin
                fold_next[l] = FOLD_W'(HALF_M - mod_val[l]);
                quad_next[l].neg_cos = 1'b1;
            end
            else if (mod_val[l] <= THREE_M)
            begin
                fold_next[l] = FOLD_W'(mod_val[l] - HALF_M);
                quad_next[l].neg_cos = 1'b1;
                quad_next[l].neg_sin = 1'b1;
            end
            else
            begin
                fold_next[l] = FOLD_W'(FULL_M - mod_val[l]);
                quad_next[l].neg_sin = 1'b1;
            end
            prod_next[l] = PROD_W'(fold_reg[l]) * PROD_W'(DEG_TO_RAD_Q30);
            rnd_sum[l]   = prod_reg[l] + PROD_W'(ROUND_HALF);
            ang_next[l]  = CORDIC_W'(rnd_sum[l] >> FRACTION_BITS);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            item_reg[0] <= point;
            for (int l = 0; l < 2; l++)
            begin
                wrap_reg[l][0] <= wrap_next[l][0];
            end
        end
        for (int s = 1; s < STAGES; s++)
        begin
            if (adv[s])
            begin
                item_reg[s] <= item_reg[s-1];
            end
        end
        for (int s = 1; s <= REDUCE_STEPS; s++)
        begin
            if (adv[s])
            begin
                for (int l = 0; l < 2; l++)
                begin
                    wrap_reg[l][s] <= wrap_next[l][s];
                end
            end
        end
        for (int l = 0; l < 2; l++)
        begin
            if (adv[FOLD_S])
            begin
                fold_reg[l]    <= fold_next[l];
                quad_reg[l][0] <= quad_next[l];
            end
            if (adv[MUL_S])
            begin
                prod_reg[l]    <= prod_next[l];
                quad_reg[l][1] <= quad_reg[l][0];
            end
            if (adv[ROUND_S])
            begin
                ang_reg[l]     <= ang_next[l];
                quad_reg[l][2] <= quad_reg[l][1];
            end
        end
    end

    // outputs
    assign point_ready         = adv[0];
    assign angle_valid         = vld_reg[STAGES-1];
    assign angle_item.item     = item_reg[STAGES-1];
    assign angle_item.az_angle = ang_reg[0];
    assign angle_item.po_angle = ang_reg[1];
    assign angle_item.az_quad  = quad_reg[0][2];
    assign angle_item.po_quad  = quad_reg[1][2];

endmodule

FILE: rtl/p2c_cordic.sv
// two-lane rotation cordic pipeline, one iteration per stage, then quadrant sign fix
`timescale 1ns / 1ps

module p2c_cordic (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               angle_valid,
    output logic               angle_ready,
    input  p2c_pkg::p2c_ang_t  angle_item,
    output logic               trig_valid,
    input  logic               trig_ready,
    output p2c_pkg::p2c_trig_t trig_item
);
    import p2c_pkg::*;

    localparam int STAGES = CORDIC_ITERS + 1;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] adv;

    p2c_in_t                    item_reg [0:STAGES-1];
    p2c_quad_t                  quad_reg [0:1][0:CORDIC_ITERS-1];
    logic signed [CORDIC_W-1:0] x_reg [0:1][1:CORDIC_ITERS];
    logic signed [CORDIC_W-1:0] y_reg [0:1][1:CORDIC_ITERS];
    logic signed [CORDIC_W-1:0] z_reg [0:1][1:CORDIC_ITERS-1];
    logic signed [CORDIC_W-1:0] x_next [0:1][1:CORDIC_ITERS];
    logic signed [CORDIC_W-1:0] y_next [0:1][1:CORDIC_ITERS];
    logic signed [CORDIC_W-1:0] z_next [0:1][1:CORDIC_ITERS-1];
    logic signed [CORDIC_W-1:0] x_src [0:1][0:CORDIC_ITERS-1];
    logic signed [CORDIC_W-1:0] y_src [0:1][0:CORDIC_ITERS-1];
    logic signed [CORDIC_W-1:0] z_src [0:1][0:CORDIC_ITERS-1];
    logic signed [CORDIC_W-1:0] cos_full [0:1];
    logic signed [CORDIC_W-1:0] sin_full [0:1];
    logic signed [DATA_W-1:0]   cos_reg [0:1];
    logic signed [DATA_W-1:0]   sin_reg [0:1];
    logic signed [DATA_W-1:0]   cos_next [0:1];
    logic signed [DATA_W-1:0]   sin_next [0:1];
    logic signed [CORDIC_W-1:0] lane_ang [0:1];
    p2c_quad_t                  lane_quad [0:1];

    // a stage moves when some stage at or after it is empty or the output drains
    always_comb
    begin
        for (int j = 0; j < STAGES; j++)
        begin
            adv[j] = trig_ready || (|(~vld_reg >> j));
        end
        vld_next = vld_reg;
        for (int j = 0; j < STAGES; j++)
        begin
            if (adv[j])
            begin
                vld_next[j] = (j == 0) ? angle_valid : vld_reg[(j == 0) ? 0 : j - 1];
            end
        end
    end

    // micro-rotations, each stage with its own fixed shift and table entry
    always_comb
    begin
        lane_ang[0]  = angle_item.az_angle;
        lane_ang[1]  = angle_item.po_angle;
        lane_quad[0] = angle_item.az_quad;
        lane_quad[1] = angle_item.po_quad;
        for (int l = 0; l < 2; l++)
        begin
            x_src[l][0] = CORDIC_GAIN;
            y_src[l][0] = '0;
            z_src[l][0] = lane_ang[l];
            for (int k = 1; k < CORDIC_ITERS; k++)
            begin
                x_src[l][k] = x_reg[l][k];
                y_src[l][k] = y_reg[l][k];
                z_src[l][k] = z_reg[l][k];
            end
            for (int k = 0; k < CORDIC_ITERS; k++)
            begin
                if (!z_src[l][k][CORDIC_W-1])
                begin
                    x_next[l][k+1] = x_src[l][k] - (y_src[l][k] >>> k);
                    y_next[l][k+1] = y_src[l][k] + (x_src[l][k] >>> k);
                end
                else
                begin
                    x_next[l][k+1] = x_src[l][k] + (y_src[l][k] >>> k);
                    y_next[l][k+1] = y_src[l][k] - (x_src[l][k] >>> k);
                end
            end
            for (int k = 0; k < CORDIC_ITERS - 1; k++)
            begin
                if (!z_src[l][k][CORDIC_W-1])
                begin
                    z_next[l][k+1] = z_src[l][k] - atan_q30(k);
                end
                else
                begin
                    z_next[l][k+1] = z_src[l][k] + atan_q30(k);
                end
            end
            // restore quadrant signs
            cos_full[l] = quad_reg[l][CORDIC_ITERS-1].neg_cos ?
                          -x_reg[l][CORDIC_ITERS] : x_reg[l][CORDIC_ITERS];
            sin_full[l] = quad_reg[l][CORDIC_ITERS-1].neg_sin ?
                          -y_reg[l][CORDIC_ITERS] : y_reg[l][CORDIC_ITERS];
            cos_next[l] = DATA_W'(cos_full[l]);
            sin_next[l] = DATA_W'(sin_full[l]);
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            item_reg[0] <= angle_item.item;
            for (int l = 0; l < 2; l++)
            begin
                quad_reg[l][0] <= lane_quad[l];
            end
        end
        for (int s = 1; s < STAGES; s++)
        begin
            if (adv[s])
            begin
                item_reg[s] <= item_reg[s-1];
            end
        end
        for (int s = 1; s < CORDIC_ITERS; s++)
        begin
            if (adv[s])
            begin
                for (int l = 0; l < 2; l++)
                begin
                    quad_reg[l][s] <= quad_reg[l][s-1];
                end
            end
        end
        for (int k = 0; k < CORDIC_ITERS; k++)
        begin
            if (adv[k])
            begin
                for (int l = 0; l < 2; l++)
                begin
                    x_reg[l][k+1] <= x_next[l][k+1];
                    y_reg[l][k+1] <= y_next[l][k+1];
                end
            end
        end
        for (int k = 0; k < CORDIC_ITERS - 1; k++)
        begin
            if (adv[k])
            begin
                for (int l = 0; l < 2; l++)
                begin
                    z_reg[l][k+1] <= z_next[l][k+1];
                end
            end
        end
        if (adv[CORDIC_ITERS])
        begin
            for (int l = 0; l < 2; l++)
            begin
                cos_reg[l] <= cos_next[l];
                sin_reg[l] <= sin_next[l];
            end
        end
    end

    // outputs
    assign angle_ready      = adv[0];
    assign trig_valid       = vld_reg[STAGES-1];
    assign trig_item.item   = item_reg[STAGES-1];
    assign trig_item.az_cos = cos_reg[0];
    assign trig_item.az_sin = sin_reg[0];
    assign trig_item.po_cos = cos_reg[1];
    assign trig_item.po_sin = sin_reg[1];

endmodule

FILE: rtl/p2c_scale.sv
// radius products with q30 rounding, type select and saturation into the result register
`timescale 1ns / 1ps

module p2c_scale (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               trig_valid,
    output logic               trig_ready,
    input  p2c_pkg::p2c_trig_t trig_item,
    output logic               result_valid,
    input  logic               result_ready,
    output p2c_pkg::p2c_out_t  result
);
    import p2c_pkg::*;

    // stage map: first products, first rounding, second products, select and clamp
    localparam int STAGES = 4;

    localparam logic [PROD1_W-1:0] HALF1 = PROD1_W'(1) << (MUL_SHIFT - 1);
    localparam logic [PROD2_W-1:0] HALF2 = PROD2_W'(1) << (MUL_SHIFT - 1);

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic [STAGES-1:0] adv;

    p2c_in_t                   item_reg [0:2];
    logic signed [DATA_W-1:0]  psin_reg [0:1];
    logic signed [PROD1_W-1:0] p_reg [0:2];
    logic signed [PROD1_W-1:0] p_next [0:2];
    logic [PROD1_W-1:0]        rnd1 [0:2];
    logic signed [RC_W-1:0]    rc_reg [0:2];
    logic signed [RC_W-1:0]    rc_next [0:2];
    logic signed [RC_W-1:0]    rc2_reg [0:2];
    logic signed [PROD2_W-1:0] q_reg [0:1];
    logic signed [PROD2_W-1:0] q_next [0:1];
    logic [PROD2_W-1:0]        rnd2 [0:1];
    logic signed [VAL_W-1:0]   qr [0:1];
    logic signed [DATA_W-1:0]  radius;
    logic signed [DATA_W-1:0]  c1;
    logic signed [DATA_W-1:0]  c2;
    logic signed [DATA_W-1:0]  c3;
    logic signed [VAL_W-1:0]   xv;
    logic signed [VAL_W-1:0]   yv;
    logic signed [VAL_W-1:0]   zv;
    logic                      known;
    logic [DATA_W:0]           sat_x;
    logic [DATA_W:0]           sat_y;
    logic [DATA_W:0]           sat_z;
    p2c_out_t                  result_reg;
    p2c_out_t                  result_next;

    // clamp to the signed field range, flag in the top bit
    function automatic logic [DATA_W:0] saturate(input logic [VAL_W-1:0] v);
        logic [VAL_W-DATA_W:0] hi;
        hi = v[VAL_W-1:DATA_W-1];
        if ((&hi) || !(|hi))
        begin
            return {1'b0, v[DATA_W-1:0]};
        end
        else if (v[VAL_W-1])
        begin
            return {1'b1, 1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            return {1'b1, 1'b0, {(DATA_W-1){1'b1}}};
        end
    endfunction

    // a stage moves when some stage at or after it is empty or the output drains
    always_comb
    begin
        for (int j = 0; j < STAGES; j++)
        begin
            adv[j] = result_ready || (|(~vld_reg >> j));
        end
        vld_next = vld_reg;
        for (int j = 0; j < STAGES; j++)
        begin
            if (adv[j])
            begin
                vld_next[j] = (j == 0) ? trig_valid : vld_reg[(j == 0) ? 0 : j - 1];
            end
        end
    end

    // radius times cosines and sine, then round to nearest
    always_comb
    begin
        radius    = trig_item.item.first_component;
        p_next[0] = radius * trig_item.az_cos;
        p_next[1] = radius * trig_item.az_sin;
        p_next[2] = radius * trig_item.po_cos;
        for (int i = 0; i < 3; i++)
        begin
            rnd1[i]    = p_reg[i] + HALF1;
            rc_next[i] = rnd1[i][PROD1_W-1:MUL_SHIFT];
        end
        // spherical second products by the polar sine
        q_next[0] = rc_reg[0] * psin_reg[1];
        q_next[1] = rc_reg[1] * psin_reg[1];
        for (int i = 0; i < 2; i++)
        begin
            rnd2[i] = q_reg[i] + HALF2;
            qr[i]   = rnd2[i][PROD2_W-1:MUL_SHIFT];
        end
    end

    // pick components by coordinate type and clamp
    always_comb
    begin
        c1    = item_reg[2].first_component;
        c2    = item_reg[2].second_component;
        c3    = item_reg[2].third_component;
        known = 1'b1;
        case (item_reg[2].operation)
            COORD_CARTESIAN:
            begin
                xv = VAL_W'(c1);
                yv = VAL_W'(c2);
                zv = VAL_W'(c3);
            end
            COORD_CYLINDRICAL:
            begin
                xv = VAL_W'(rc2_reg[0]);
                yv = VAL_W'(rc2_reg[1]);
                zv = VAL_W'(c3);
            end
            COORD_SPHERICAL:
            begin
                xv = qr[0];
                yv = qr[1];
                zv = VAL_W'(rc2_reg[2]);
            end
            default:
            begin
                xv    = '0;
                yv    = '0;
                zv    = '0;
                known = 1'b0;
            end
        endcase
        sat_x = saturate(xv);
        sat_y = saturate(yv);
        sat_z = saturate(zv);
        result_next.x_out      = sat_x[DATA_W-1:0];
        result_next.y_out      = sat_y[DATA_W-1:0];
        result_next.z_out      = sat_z[DATA_W-1:0];
        result_next.type_valid = known;
        result_next.saturated  = sat_x[DATA_W] | sat_y[DATA_W] | sat_z[DATA_W];
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // stage payloads
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            item_reg[0] <= trig_item.item;
            psin_reg[0] <= trig_item.po_sin;
            for (int i = 0; i < 3; i++)
            begin
                p_reg[i] <= p_next[i];
            end
        end
        if (adv[1])
        begin
            item_reg[1] <= item_reg[0];
            psin_reg[1] <= psin_reg[0];
            for (int i = 0; i < 3; i++)
            begin
                rc_reg[i] <= rc_next[i];
            end
        end
        if (adv[2])
        begin
            item_reg[2] <= item_reg[1];
            for (int i = 0; i < 3; i++)
            begin
                rc2_reg[i] <= rc_reg[i];
            end
            for (int i = 0; i < 2; i++)
            begin
                q_reg[i] <= q_next[i];
            end
        end
        if (adv[3])
        begin
            result_reg <= result_next;
        end
    end

    // outputs
    assign trig_ready   = adv[0];
    assign result_valid = vld_reg[STAGES-1];
    assign result       = result_reg;

endmodule
